/* rtl/vtcf_pkg.sv */
// Package for the vsync timing change filter: payload types, states and constants.
`default_nettype none
package vtcf_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned THR_W     = 16;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(25);

    typedef struct packed {
        logic [DATA_W-1:0] vsync_base;
        logic [DATA_W-1:0] vsync_period;
    } vtcf_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] timebase_low;
        logic [HALF_W-1:0] timebase_high;
        logic [HALF_W-1:0] interval_low;
        logic [HALF_W-1:0] interval_high;
    } vtcf_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } vtcf_div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_CMP,
        ST_OUT
    } vtcf_state_t;

endpackage
`default_nettype wire

/* rtl/vtcf_divider.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module vtcf_divider (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               start,
    input  wire [vtcf_pkg::DATA_W-1:0]        dividend,
    input  wire [vtcf_pkg::DATA_W-1:0]        divisor,
    output vtcf_pkg::vtcf_div_status_t        status,
    output logic [vtcf_pkg::DATA_W-1:0]       remainder
);
    import vtcf_pkg::*;

    logic [DATA_W-1:0]    dvd_reg, dvd_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;

    always_comb begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, dvd_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract where it fits
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            rem_next = trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule
`default_nettype wire

/* rtl/vsync_timing_change_filter_core.sv */
// Top level of the vsync timing change filter: control, decision and output register.
`default_nettype none
// An item with a nonzero interval goes through these steps from acceptance
// until its result is loaded: the bit-serial remainder unit (one dividend
// bit per cycle), the step that sees the unit's finish flag and takes the
// offset difference, a spare step, the threshold compare and the load of
// the output register. A suppressed item returns to idle after the compare,
// an emitted one after the load. An item with a zero interval is dropped at
// acceptance and the block is ready again at once. The next item is accepted
// while a result still waits in the output register; a new result that finds
// the register full holds until it is taken.
module vsync_timing_change_filter_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  vtcf_pkg::vtcf_in_t              s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output vtcf_pkg::vtcf_out_t             m_data,
    input  wire                             cfg_wr_en,
    input  wire [vtcf_pkg::THR_W-1:0]       cfg_wr_data
);
    import vtcf_pkg::*;

    vtcf_state_t        state_reg, state_next;
    logic [THR_W-1:0]   thr_reg;
    logic [DATA_W-1:0]  tb_reg, tb_next;
    logic [DATA_W-1:0]  iv_reg, iv_next;
    logic [DATA_W-1:0]  diff_reg, diff_next;
    logic               same_reg, same_next;
    logic [DATA_W-1:0]  sent_iv_reg, sent_iv_next;
    logic [DATA_W-1:0]  sent_off_reg, sent_off_next;
    logic               m_valid_reg, m_valid_next;
    vtcf_out_t          m_data_reg, m_data_next;
    logic               accept;
    logic               div_start;
    logic [DATA_W-1:0]  mag;
    vtcf_div_status_t   div_status;
    logic [DATA_W-1:0]  remainder;

    vtcf_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_data.vsync_base),
        .divisor   (s_data.vsync_period),
        .status    (div_status),
        .remainder (remainder)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign mag     = diff_reg[DATA_W-1] ? (DATA_W'(0) - diff_reg) : diff_reg;

    always_comb begin
        state_next    = state_reg;
        tb_next       = tb_reg;
        iv_next       = iv_reg;
        diff_next     = diff_reg;
        same_next     = same_reg;
        sent_iv_next  = sent_iv_reg;
        sent_off_next = sent_off_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // drop a zero interval right here
                if (accept && (s_data.vsync_period != '0)) begin
                    tb_next    = s_data.vsync_base;
                    iv_next    = s_data.vsync_period;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    diff_next  = sent_off_reg - remainder;
                    same_next  = (iv_reg == sent_iv_reg);
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (same_reg && (mag < DATA_W'(thr_reg))) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.timebase_low  = tb_reg[HALF_W-1:0];
                    m_data_next.timebase_high = tb_reg[DATA_W-1:HALF_W];
                    m_data_next.interval_low  = iv_reg[HALF_W-1:0];
                    m_data_next.interval_high = iv_reg[DATA_W-1:HALF_W];
                    sent_iv_next              = iv_reg;
                    sent_off_next             = remainder;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THRESHOLD_RESET;
            sent_iv_reg  <= '0;
            sent_off_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sent_iv_reg  <= sent_iv_next;
            sent_off_reg <= sent_off_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
        tb_reg     <= tb_next;
        iv_reg     <= iv_next;
        diff_reg   <= diff_next;
        same_reg   <= same_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.vsync_period != '0)) |=> !s_ready)
        else $error("block ready right after starting an item");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside the divide state");

    a_rem_below_iv: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV) && div_status.done) |-> (remainder < iv_reg))
        else $error("remainder not below interval");

    a_idle_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_status.busy)
        else $error("divider busy while idle");

endmodule
`default_nettype wire

/* dv/vsync_timing_change_filter_core_tb.sv */
// Self-checking testbench for the vsync timing change filter core.
module vsync_timing_change_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vtcf_pkg::*;

    localparam int SETTLE_CYCLES = 80;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    vtcf_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    vtcf_out_t  m_data;
    logic       cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    // predictor state
    logic [DATA_W-1:0] last_interval = '0;
    logic [DATA_W-1:0] last_offset = '0;
    logic [THR_W-1:0]  offset_threshold = THRESHOLD_RESET;

    vtcf_out_t pending_updates[$];
    vtcf_out_t expected_upd;
    int        errors = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    vsync_timing_change_filter_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #10_000_000;
        $display("FAIL vsync_timing_change_filter_core");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Returns 1 and the update when the beat gets through the filter.
    function automatic bit predict_update(input vtcf_in_t beat, output vtcf_out_t upd);
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] diff;
        logic [DATA_W-1:0] mag;
        upd = '0;
        if (beat.vsync_period == '0)
            return 1'b0;
        off = beat.vsync_base % beat.vsync_period;
        if (beat.vsync_period == last_interval) begin
            diff = last_offset - off;
            mag = diff[DATA_W-1] ? (64'd0 - diff) : diff;
            if (mag < {48'd0, offset_threshold})
                return 1'b0;
        end
        upd.timebase_low  = beat.vsync_base[31:0];
        upd.timebase_high = beat.vsync_base[63:32];
        upd.interval_low  = beat.vsync_period[31:0];
        upd.interval_high = beat.vsync_period[63:32];
        last_interval = beat.vsync_period;
        last_offset = off;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Result side: compare every update beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_updates.size() == 0) begin
                errors++;
                $display("%0t: unexpected update, expected none actual %h", $time, m_data);
            end else begin
                expected_upd = pending_updates.pop_front();
                check_field("timebase_low", expected_upd.timebase_low, m_data.timebase_low);
                check_field("timebase_high", expected_upd.timebase_high,
                            m_data.timebase_high);
                check_field("interval_low", expected_upd.interval_low, m_data.interval_low);
                check_field("interval_high", expected_upd.interval_high,
                            m_data.interval_high);
            end
        end
    end

    // Result side back-pressure.
    initial begin : rx_side
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_beat(input logic [63:0] tb, input logic [63:0] iv);
        vtcf_in_t  item;
        vtcf_out_t upd;
        int        gap;
        item.vsync_base = tb;
        item.vsync_period = iv;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (predict_update(item, upd))
            pending_updates.push_back(upd);
    endtask

    // Hold off until every update is out and any dropped beat has finished.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        offset_threshold = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int count);
        int                n;
        int                kind;
        int                span;
        longint signed     delta;
        logic [63:0]       iv;
        logic [63:0]       tb;
        logic [63:0]       target;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                // zero-interval noise, not counted
                send_beat(rand64(), '0);
                continue;
            end
            if (kind < 70 && last_interval != '0) begin
                // same interval, offset near the last one sent
                iv = last_interval;
                span = int'(offset_threshold) + 3;
                delta = longint'($urandom_range(0, 2 * span)) - span;
                target = last_offset + delta;
                if (target >= iv)
                    target = (delta < 0) ? 64'd0 : iv - 64'd1;
                if ($urandom_range(0, 7) == 0)
                    tb = rand64();
                else
                    tb = (rand64() / iv) * iv + target;
            end else begin
                case ($urandom_range(0, 5))
                    0: iv = 64'($urandom_range(1, 64));
                    1: iv = 64'($urandom_range(16000, 17000));
                    2: iv = {32'd0, $urandom};
                    3: iv = rand64();
                    4: begin
                        case ($urandom_range(0, 5))
                            0: iv = 64'd1;
                            1: iv = '1;
                            2: iv = 64'h8000_0000_0000_0000;
                            3: iv = 64'h8000_0000_0000_0001;
                            4: iv = 64'h1_0000_0000;
                            default: iv = 64'hFFFF_FFFF;
                        endcase
                    end
                    default: iv = rand64() >> $urandom_range(0, 63);
                endcase
                if (iv == '0)
                    iv = 64'd1;
                tb = rand64() >> $urandom_range(0, 3) * 16;
            end
            send_beat(tb, iv);
            n++;
        end
        drain_and_settle();
    endtask

    task automatic test_directed_cases();
        send_beat(rand64(), '0);                        // dropped before any update
        send_beat(64'd1000, 64'd100);                   // first beat always passes
        send_beat(64'd1010, 64'd100);                   // small change, suppress
        send_beat(64'd1024, 64'd100);                   // just under threshold
        send_beat(64'd1025, 64'd100);                   // at threshold, pass
        send_beat(64'd1000, 64'd100);                   // positive difference at threshold
        send_beat('1, '1);
        send_beat('0, '1);
        send_beat('1, '0);
        send_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_beat('0, 64'h8000_0000_0000_0001);         // most negative difference
        send_beat(64'hFFFF_FFFF_0000_0001, 64'h1_0000_0000);
        send_beat(64'h0000_0001_FFFF_FFFF, 64'h1_0000_0000);
        send_beat(64'd5, 64'd1);
        send_beat(rand64(), 64'd1);
        send_beat(64'd7, 64'hFFFF_FFFF_FFFF_FFFE);      // timebase below interval
        drain_and_settle();
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_beat(64'd7, 64'hFFFF_FFFF_FFFF_FFFE);      // no change still passes
        random_traffic(110);
        write_threshold('1);
        send_beat(64'd7, 64'd1_000_000);
        send_beat(64'd65541, 64'd1_000_000);            // one under max threshold
        send_beat(64'd65542, 64'd1_000_000);
        random_traffic(110);
    endtask

    task automatic test_random_thresholds();
        write_threshold(16'd1);
        random_traffic(115);
        write_threshold(THR_W'($urandom_range(0, 65535)));
        random_traffic(115);
        write_threshold(THR_W'($urandom_range(2, 300)));
        random_traffic(115);
        write_threshold(THRESHOLD_RESET);
        random_traffic(115);
    endtask

    initial begin : main
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_threshold_extremes();
        test_random_thresholds();
        if (errors == 0)
            $display("PASS vsync_timing_change_filter_core");
        else
            $display("FAIL vsync_timing_change_filter_core");
        $finish;
    end

endmodule

/* sim.f */
rtl/vtcf_pkg.sv
rtl/vtcf_divider.sv
rtl/vsync_timing_change_filter_core.sv
dv/vsync_timing_change_filter_core_tb.sv
